// File: design/brbd_pkg.sv
// ============================================================================
// brbd_pkg
// Shared constants for the RGGB bilinear demosaic unit: field widths,
// configuration register indexes and register reset values.
// ============================================================================
`default_nettype none

package brbd_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int COLUMN_W   = 11;
    localparam int ROW_OUT_W  = 12;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 48;

    localparam int MAX_LINE_WIDTH_DEF = 2048;
    localparam int MAX_ROWS_DEF       = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_RAW_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT     = 2'd2;

    localparam logic [CFG_W-1:0] RAW_LINE_WIDTH_RST = 12'd1440;
    localparam logic [CFG_W-1:0] OUT_WIDTH_RST      = 12'd1440;
    localparam logic [CFG_W-1:0] OUT_HEIGHT_RST     = 12'd1080;

endpackage

`default_nettype wire

// File: design/bayer_rggb_bilinear_demosaic_unit.sv
// ============================================================================
// bayer_rggb_bilinear_demosaic_unit
// Bilinear demosaic of a raster-order RGGB Bayer stream with two line stores
// and a 3x3 window; emits RGB for interior pixels only.
// ============================================================================
// The unit takes one raw sample per clock and sustains one word per clock in
// each direction as long as the output side is ready. A result reaches the
// output register from the raw sample that completes its window (lower-right
// neighbor) via the registered line store read and the interpolation. Border
// pixels produce no word, so the consumer must clear its frame buffer. The
// two previous raw lines live in one memory that is read and written back
// once per sample, with the write forwarded when a sample reads the column
// that the sample ahead of it is writing back, as on a line a single sample
// wide. A sample with tuser set restarts the frame at column 0, row 0; tlast
// marks the last interior pixel. The user must write configuration only while
// no sample is in flight; the block itself does not enforce it.
`default_nettype none

module bayer_rggb_bilinear_demosaic_unit #(
    parameter int MAX_LINE_WIDTH = brbd_pkg::MAX_LINE_WIDTH_DEF,
    parameter int MAX_ROWS       = brbd_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [brbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [brbd_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // raw_pixel[7:0]
    input  wire logic [brbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // frame_start[0]
    input  wire logic                                 s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], column[34:24], row[46:35], zero[47]
    output logic [brbd_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // frame_done
    output logic                                      m_axis_tlast
);

    localparam int PW    = brbd_pkg::PIX_W;
    localparam int CW    = brbd_pkg::CFG_W;
    localparam int XW    = brbd_pkg::COLUMN_W;
    localparam int YW    = brbd_pkg::ROW_OUT_W;
    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CMP_A = (COL_W + 1 > CW) ? COL_W + 1 : CW;
    localparam int CMP_W = ((CMP_A > ROW_W) ? CMP_A : ROW_W) + 1;
    localparam int SUM_W = PW + 2;

    typedef enum logic [1:0] {
        SITE_RED,
        SITE_GREEN_R,
        SITE_GREEN_B,
        SITE_BLUE
    } site_t;

    typedef struct packed {
        logic [PW-1:0] top;
        logic [PW-1:0] mid;
        logic [PW-1:0] bot;
    } win_col_t;

    // configuration
    logic [CW-1:0] raw_width_reg;
    logic [CW-1:0] out_width_reg;
    logic [CW-1:0] out_height_reg;

    // position of the next raw sample
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;

    // interpolation stage
    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_done_reg;
    site_t             s1_site_reg;
    logic [XW-1:0]     s1_x_reg;
    logic [YW-1:0]     s1_y_reg;
    logic [PW-1:0]     s1_pix_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    win_col_t          win1_reg;
    win_col_t          win0_reg;

    // output register
    logic              out_valid_reg;
    logic [PW-1:0]     out_red_reg;
    logic [PW-1:0]     out_green_reg;
    logic [PW-1:0]     out_blue_reg;
    logic [XW-1:0]     out_col_reg;
    logic [YW-1:0]     out_row_reg;
    logic              out_done_reg;

    logic              pipe_en;
    logic              accept;
    logic [CMP_W-1:0]  rw_ext;
    logic [CMP_W-1:0]  rw_eff;
    logic [CMP_W-1:0]  ow_ext;
    logic [CMP_W-1:0]  ow_eff;
    logic [CMP_W-1:0]  oh_eff;
    logic [COL_W-1:0]  c_cur;
    logic [ROW_W-1:0]  r_cur;
    logic [CMP_W-1:0]  c_ext;
    logic [CMP_W-1:0]  r_ext;
    logic              emit_next;
    logic              done_next;
    site_t             site_next;
    logic [COL_W-1:0]  x_full;
    logic [ROW_W-1:0]  y_full;

    logic [2*PW-1:0]   ls_rdata;
    logic [2*PW-1:0]   ls_wdata;
    logic [PW-1:0]     p02;
    logic [PW-1:0]     p12;
    logic [PW-1:0]     p22;
    logic [SUM_W-1:0]  horiz_sum;
    logic [SUM_W-1:0]  vert_sum;
    logic [SUM_W-1:0]  cross_sum;
    logic [SUM_W-1:0]  diag_sum;
    logic [PW-1:0]     horiz;
    logic [PW-1:0]     vert;
    logic [PW-1:0]     cross_avg;
    logic [PW-1:0]     diag;
    logic [PW-1:0]     red_next;
    logic [PW-1:0]     green_next;
    logic [PW-1:0]     blue_next;

    assign pipe_en       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = pipe_en;
    assign accept        = s_axis_tvalid && pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_width_reg  <= brbd_pkg::RAW_LINE_WIDTH_RST;
            out_width_reg  <= brbd_pkg::OUT_WIDTH_RST;
            out_height_reg <= brbd_pkg::OUT_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                brbd_pkg::REG_RAW_LINE_WIDTH: raw_width_reg  <= cfg_data;
                brbd_pkg::REG_OUT_WIDTH:      out_width_reg  <= cfg_data;
                brbd_pkg::REG_OUT_HEIGHT:     out_height_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Effective geometry and the window position of the incoming sample.
    always_comb
    begin
        rw_ext = CMP_W'(raw_width_reg);
        if (rw_ext == '0)
            rw_eff = CMP_W'(1);
        else if (rw_ext > CMP_W'(MAX_LINE_WIDTH))
            rw_eff = CMP_W'(MAX_LINE_WIDTH);
        else
            rw_eff = rw_ext;
        ow_ext = CMP_W'(out_width_reg);
        ow_eff = (ow_ext > rw_eff) ? rw_eff : ow_ext;
        oh_eff = CMP_W'(out_height_reg);

        c_cur = s_axis_tuser ? '0 : col_reg;
        r_cur = s_axis_tuser ? '0 : row_reg;
        c_ext = CMP_W'(c_cur);
        r_ext = CMP_W'(r_cur);

        emit_next = (ow_eff >= CMP_W'(3)) && (oh_eff >= CMP_W'(3)) &&
                    (c_ext >= CMP_W'(2)) && (c_ext <= ow_eff - CMP_W'(1)) &&
                    (r_ext >= CMP_W'(2)) && (r_ext <= oh_eff - CMP_W'(1));
        done_next = (c_ext == ow_eff - CMP_W'(1)) && (r_ext == oh_eff - CMP_W'(1));

        x_full = c_cur - COL_W'(1);
        y_full = r_cur - ROW_W'(1);
        case ({y_full[0], x_full[0]})
            2'b00:   site_next = SITE_RED;
            2'b01:   site_next = SITE_GREEN_R;
            2'b10:   site_next = SITE_GREEN_B;
            default: site_next = SITE_BLUE;
        endcase

        if (c_ext + CMP_W'(1) >= rw_eff)
        begin
            col_next = '0;
            row_next = (r_cur < ROW_W'(MAX_ROWS - 1)) ? r_cur + ROW_W'(1) : r_cur;
        end
        else
        begin
            col_next = c_cur + COL_W'(1);
            row_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    brbd_line_store #(
        .DEPTH  (MAX_LINE_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (2 * PW)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .wr_en   (s1_valid_reg && pipe_en),
        .wr_addr (s1_addr_reg),
        .wr_data (ls_wdata),
        .rd_data (ls_rdata)
    );

    assign p02      = ls_rdata[2*PW-1:PW];
    assign p12      = ls_rdata[PW-1:0];
    assign p22      = s1_pix_reg;
    assign ls_wdata = {p12, p22};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            win1_reg     <= '0;
            win0_reg     <= '0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= s_axis_tvalid;
            if (s1_valid_reg)
            begin
                win1_reg <= '{top: p02, mid: p12, bot: p22};
                win0_reg <= win1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= emit_next;
            s1_done_reg <= done_next;
            s1_site_reg <= site_next;
            s1_x_reg    <= XW'(x_full);
            s1_y_reg    <= YW'(y_full);
            s1_pix_reg  <= s_axis_tdata[PW-1:0];
            s1_addr_reg <= c_cur;
        end
    end

    always_comb
    begin
        horiz_sum = SUM_W'(win0_reg.mid) + SUM_W'(p12);
        vert_sum  = SUM_W'(win1_reg.top) + SUM_W'(win1_reg.bot);
        cross_sum = vert_sum + horiz_sum;
        diag_sum  = SUM_W'(win0_reg.top) + SUM_W'(p02) + SUM_W'(win0_reg.bot) + SUM_W'(p22);
        horiz     = horiz_sum[PW:1];
        vert      = vert_sum[PW:1];
        cross_avg = cross_sum[PW+1:2];
        diag      = diag_sum[PW+1:2];

        case (s1_site_reg)
            SITE_RED:
            begin
                red_next   = win1_reg.mid;
                green_next = cross_avg;
                blue_next  = diag;
            end
            SITE_GREEN_R:
            begin
                red_next   = horiz;
                green_next = win1_reg.mid;
                blue_next  = vert;
            end
            SITE_GREEN_B:
            begin
                red_next   = vert;
                green_next = win1_reg.mid;
                blue_next  = horiz;
            end
            default:
            begin
                red_next   = diag;
                green_next = cross_avg;
                blue_next  = win1_reg.mid;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && s1_valid_reg && s1_emit_reg)
        begin
            out_red_reg   <= red_next;
            out_green_reg <= green_next;
            out_blue_reg  <= blue_next;
            out_col_reg   <= s1_x_reg;
            out_row_reg   <= s1_y_reg;
            out_done_reg  <= s1_done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_row_reg, out_col_reg, out_blue_reg,
                            out_green_reg, out_red_reg};
    assign m_axis_tlast  = out_done_reg;

    // A sample held in the interpolation stage is not lost while stalled.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !pipe_en |=> s1_valid_reg)
        else $error("interpolation stage dropped a sample during a stall");

    // Interior pixels never sit on row zero.
    a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_row_reg != '0)
        else $error("emitted a pixel on the top border row");

    // A frame start leaves the column counter at the second column or wrapped.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tuser |=> (col_reg == COL_W'(1) || col_reg == '0))
        else $error("frame start did not restart the column counter");

    // The stage does not take a new sample while the output is stalled.
    a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> $stable(s1_pix_reg))
        else $error("sample accepted while the output was stalled");

endmodule

`default_nettype wire

// File: design/brbd_line_store.sv
// ============================================================================
// brbd_line_store
// Two raw line stores kept side by side in one synchronous memory word
// (upper line in the high byte, middle line in the low byte). The read data
// is registered; a write to the entry being read in the same cycle is
// forwarded so that a read always returns the newest contents.
// ============================================================================
`default_nettype none

module brbd_line_store #(
    parameter int DEPTH  = brbd_pkg::MAX_LINE_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 2 * brbd_pkg::PIX_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic              fwd_next;

    assign fwd_next = rd_en && wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb_bayer_rggb_bilinear_demosaic_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_bayer_rggb_bilinear_demosaic_unit
// Self-checking testbench for the RGGB bilinear demosaic unit. A clocked
// driver feeds raw Bayer words from a queue in random bursts. A clocked
// monitor applies its own backpressure and compares every RGB word with a
// demosaic predictor kept in the testbench. The run walks through many small
// frame geometries, from degenerate lines to frames with spare raw columns.
// ============================================================================

module tb_bayer_rggb_bilinear_demosaic_unit;

    localparam logic [brbd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        bit [7:0] pixel;
        bit       frame_start;
    } raw_word_t;

    typedef struct {
        bit [7:0]  red;
        bit [7:0]  green;
        bit [7:0]  blue;
        bit [10:0] column;
        bit [11:0] row;
        bit        frame_done;
    } rgb_word_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [brbd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [brbd_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [brbd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [brbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;

    raw_word_t raw_pending[$];
    rgb_word_t rgb_expected[$];

    bit [11:0] cfg_raw_width = brbd_pkg::RAW_LINE_WIDTH_RST;
    bit [11:0] cfg_out_width = brbd_pkg::OUT_WIDTH_RST;
    bit [11:0] cfg_out_height = brbd_pkg::OUT_HEIGHT_RST;
    bit [7:0]  line_two_up [brbd_pkg::MAX_LINE_WIDTH_DEF];
    bit [7:0]  line_one_up [brbd_pkg::MAX_LINE_WIDTH_DEF];
    bit [47:0] window_cols = '0;
    int unsigned next_col = 0;
    int unsigned next_row = 0;

    int unsigned words_queued = 0;
    int unsigned words_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned geometries = 0;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    raw_word_t   drive_word;

    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned pattern_left = 0;
    int unsigned stall_pct = 0;
    rgb_word_t   want;

    bayer_rggb_bilinear_demosaic_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    task automatic demosaic_predict(input bit [7:0] pix, input bit fs);
        int unsigned eff_raw, eff_out, eff_h, c, r, x, y;
        int unsigned horiz, vert, cross_avg, diag;
        bit [7:0] nb [3][3];
        rgb_word_t px;
        begin
            if (fs)
            begin
                next_col = 0;
                next_row = 0;
            end
            eff_raw = 32'(cfg_raw_width);
            if (eff_raw < 1)
                eff_raw = 1;
            if (eff_raw > brbd_pkg::MAX_LINE_WIDTH_DEF)
                eff_raw = brbd_pkg::MAX_LINE_WIDTH_DEF;
            eff_out = 32'(cfg_out_width);
            if (eff_out > eff_raw)
                eff_out = eff_raw;
            eff_h = 32'(cfg_out_height);
            c = next_col;
            r = next_row;

            nb[0][2] = line_two_up[c[10:0]];
            nb[1][2] = line_one_up[c[10:0]];
            nb[2][2] = pix;
            line_two_up[c[10:0]] = nb[1][2];
            line_one_up[c[10:0]] = pix;
            {nb[2][0], nb[1][0], nb[0][0], nb[2][1], nb[1][1], nb[0][1]} = window_cols;

            if (eff_out >= 3 && eff_h >= 3 && c >= 2 && c <= eff_out - 1 &&
                r >= 2 && r <= eff_h - 1)
            begin
                x = c - 1;
                y = r - 1;
                horiz = (int'(nb[1][0]) + nb[1][2]) >> 1;
                vert = (int'(nb[0][1]) + nb[2][1]) >> 1;
                cross_avg = (int'(nb[0][1]) + nb[2][1] + nb[1][0] + nb[1][2]) >> 2;
                diag = (int'(nb[0][0]) + nb[0][2] + nb[2][0] + nb[2][2]) >> 2;
                case ({y[0], x[0]})
                    2'b00:
                    begin
                        px.red = nb[1][1];
                        px.green = cross_avg[7:0];
                        px.blue = diag[7:0];
                    end
                    2'b01:
                    begin
                        px.red = horiz[7:0];
                        px.green = nb[1][1];
                        px.blue = vert[7:0];
                    end
                    2'b10:
                    begin
                        px.red = vert[7:0];
                        px.green = nb[1][1];
                        px.blue = horiz[7:0];
                    end
                    default:
                    begin
                        px.red = diag[7:0];
                        px.green = cross_avg[7:0];
                        px.blue = nb[1][1];
                    end
                endcase
                px.column = x[10:0];
                px.row = y[11:0];
                px.frame_done = (c == eff_out - 1) && (r == eff_h - 1);
                rgb_expected.push_back(px);
            end

            window_cols = {window_cols[23:0], pix, nb[1][2], nb[0][2]};
            if (c + 1 >= eff_raw)
            begin
                next_col = 0;
                if (r < brbd_pkg::MAX_ROWS_DEF - 1)
                    next_row = r + 1;
            end
            else
                next_col = c + 1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        begin
            if (exp_v != act_v)
            begin
                mismatches++;
                if (mismatches <= 50)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, exp_v, act_v);
            end
        end
    endtask

    task automatic queue_pixel(input bit [7:0] pix, input bit fs);
        raw_word_t w;
        begin
            w.pixel = pix;
            w.frame_start = fs;
            raw_pending.push_back(w);
            words_queued++;
        end
    endtask

    task automatic send_frame(input int unsigned width, input int unsigned rows,
                              input int unsigned cut, input bit noisy);
        int unsigned total, mode, i;
        bit [7:0] pix;
        bit fs;
        begin
            total = width * rows;
            if (cut != 0 && cut < total)
                total = cut;
            mode = $urandom_range(0, 9);
            for (i = 0; i < total; i++)
            begin
                case (mode)
                    0: pix = 8'hFF;
                    1: pix = 8'h00;
                    2: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: pix = 8'($urandom);
                endcase
                fs = (i == 0) || (noisy && $urandom_range(0, 199) == 0);
                queue_pixel(pix, fs);
            end
        end
    endtask

    task automatic set_geometry(input bit [11:0] rw, input bit [11:0] ow,
                                input bit [11:0] oh, input bit spare);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= brbd_pkg::REG_RAW_LINE_WIDTH;
            cfg_data <= rw;
            @(posedge clk);
            cfg_index <= brbd_pkg::REG_OUT_WIDTH;
            cfg_data <= ow;
            @(posedge clk);
            cfg_index <= brbd_pkg::REG_OUT_HEIGHT;
            cfg_data <= oh;
            if (spare)
            begin
                @(posedge clk);
                cfg_index <= REG_SPARE;
                cfg_data <= 12'($urandom);
            end
            @(posedge clk);
            cfg_we <= 1'b0;
            cfg_raw_width = rw;
            cfg_out_width = ow;
            cfg_out_height = oh;
            geometries++;
        end
    endtask

    task automatic wait_idle;
        int unsigned quiet;
        begin
            while (words_accepted != words_queued || rgb_expected.size() != 0)
                @(posedge clk);
            quiet = 0;
            while (quiet < 8)
            begin
                @(posedge clk);
                if (m_axis_tready)
                    quiet++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                demosaic_predict(s_axis_tdata, s_axis_tuser);
                words_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (raw_pending.size() != 0)
                begin
                    drive_word = raw_pending.pop_front();
                    s_axis_tdata <= drive_word.pixel;
                    s_axis_tuser <= drive_word.frame_start;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(100, 400) : $urandom_range(1, 40);
                        gap_left = $urandom_range(0, 6);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (rgb_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 50)
                        $display("%0t: unexpected word, expected none, actual tdata %h",
                                 $time, m_axis_tdata);
                end
                else
                begin
                    want = rgb_expected.pop_front();
                    check_field("red", 32'(want.red), 32'(m_axis_tdata[7:0]));
                    check_field("green", 32'(want.green), 32'(m_axis_tdata[15:8]));
                    check_field("blue", 32'(want.blue), 32'(m_axis_tdata[23:16]));
                    check_field("column", 32'(want.column), 32'(m_axis_tdata[34:24]));
                    check_field("row", 32'(want.row), 32'(m_axis_tdata[46:35]));
                    check_field("frame_done", 32'(want.frame_done), 32'(m_axis_tlast));
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 150 && raw_pending.size() >= 4)
            begin
                hold_done = 1'b1;
                hold_left = 400;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 10;
                        2: stall_pct = 40;
                        default: stall_pct = 75;
                    endcase
                end
                else
                    pattern_left--;
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int unsigned i, f, rw, ow, oh, eff, rows, cut, random_start;
        bit [7:0] pix;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Small frame with a spare raw column; the first word carries no
        // frame start, so the counters must start from reset.
        set_geometry(12'd5, 12'd4, 12'd4, 1'b1);
        for (i = 0; i < 24; i++)
        begin
            case (i % 4)
                0: pix = 8'hFF;
                1: pix = 8'h00;
                2: pix = 8'hFF;
                default: pix = 8'(i * 53);
            endcase
            queue_pixel(pix, i == 23);
        end

        random_start = words_queued;
        while (words_queued - random_start < 1200)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    rw = $urandom_range(0, 2);
                    ow = $urandom_range(0, 6);
                    oh = $urandom_range(0, 6);
                end
                1:
                begin
                    rw = $urandom_range(3, 10);
                    ow = $urandom_range(0, 1) ? 4095 : rw + $urandom_range(1, 4);
                    oh = $urandom_range(3, 6);
                end
                2:
                begin
                    rw = $urandom_range(3, 10);
                    if ($urandom_range(0, 1))
                    begin
                        ow = $urandom_range(0, 2);
                        oh = $urandom_range(3, 6);
                    end
                    else
                    begin
                        ow = $urandom_range(3, rw);
                        oh = $urandom_range(0, 2);
                    end
                end
                default:
                begin
                    rw = $urandom_range(3, 16);
                    ow = $urandom_range(3, rw);
                    oh = $urandom_range(3, 8);
                end
            endcase
            wait_idle();
            set_geometry(12'(rw), 12'(ow), 12'(oh), 1'b0);
            eff = (rw == 0) ? 1 : rw;
            for (f = $urandom_range(1, 3); f > 0; f--)
            begin
                rows = (oh < 3) ? $urandom_range(3, 5) : oh + $urandom_range(0, 2);
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, eff * rows - 1) : 0;
                send_frame(eff, rows, cut, 1'b1);
            end
        end

        wait_idle();
        $display("Run covered %0d raw words over %0d geometry settings and checked %0d RGB words.",
                 words_accepted, geometries, results_seen);
        $display("Geometries ranged from one-sample lines to small frames with spare columns.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: bayer_rggb_bilinear_demosaic_unit.f
design/brbd_pkg.sv
design/brbd_line_store.sv
design/bayer_rggb_bilinear_demosaic_unit.sv
tb/sv/tb_bayer_rggb_bilinear_demosaic_unit.sv
